// ===== src/mm4_pkg.sv =====
// shared types and constants for the 4x4 fixed-point matrix multiplier
package mm4_pkg;

  localparam int unsigned DIM          = 4;
  localparam int unsigned ELEMENT_BITS = 32;
  localparam int unsigned CELLS        = DIM * DIM;
  localparam int unsigned DIM_W        = $clog2(DIM);
  localparam int unsigned CELL_W       = $clog2(CELLS);
  localparam int unsigned PROD_W       = 2 * ELEMENT_BITS;
  localparam int unsigned ACC_W        = PROD_W + DIM_W;
  localparam int unsigned FRAC_W       = 5;
  localparam int unsigned INDEX_W      = 4;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned DATA_W       = 32;

  // register index taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_FRACTION_BITS = '0;
  localparam logic [FRAC_W-1:0] FRACTION_RESET    = 5'd16;

  typedef struct packed {
    logic signed [31:0] left_element;
    logic signed [31:0] right_element;
  } mm4_in_t;

  typedef struct packed {
    logic signed [31:0]  product_element;
    logic [INDEX_W-1:0]  element_index;
    logic                last_element;
    logic                saturated;
  } mm4_out_t;

  // control flags for one operand pair of the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm4_mac_ctrl_t;

endpackage

// ===== src/matrix4_multiply.sv =====
// top level of the 4x4 signed fixed-point matrix multiplier
//
// input channel: sixteen requests, each carrying the elements of A and B at
// the same column-major index. a request is taken when in_valid_i is high and
// in_stall_o is low, one per cycle while loading.
// after the sixteenth request the block stalls its input and works out the
// sixteen elements of A*B in column-major order on one shared 32x32
// multiply-accumulate unit: four products per element, then an arithmetic
// shift by fraction_bits and saturation to 32 bits.
// each element takes 4 operand reads, then the registered product and the
// accumulator drain through the multiply-accumulate unit, then the result
// is registered in the output register. the next element starts only once
// the current result is taken.
// output channel: a result is held in the output register until it is taken
// (out_valid_o high and out_stall_i low); while stalled
// the block waits and the result does not change. last_element marks the
// final element, after which loading starts again.
// reset clears the load count, the sequencer and fraction_bits (to 16).
// fraction_bits sits at byte address 0 of the APB port, pready always high.
module matrix4_multiply import mm4_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mm4_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mm4_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } mm4_state_e;

  mm4_state_e state_q, state_d;

  logic [FRAC_W-1:0] frac_q;
  logic              cfg_write;
  logic              cfg_hit;

  logic [CELL_W-1:0] load_cnt_q;
  logic [CELL_W-1:0] cell_q;
  logic [DIM_W-1:0]  k_q;
  logic              in_accept;
  logic              out_accept;

  logic signed [ELEMENT_BITS-1:0] left_mem  [CELLS];
  logic signed [ELEMENT_BITS-1:0] right_mem [CELLS];
  logic signed [ELEMENT_BITS-1:0] rd_a_q, rd_b_q;
  mm4_mac_ctrl_t                  rd_ctrl_q, rd_ctrl_d;

  logic [DIM_W-1:0]  cur_row, cur_col;
  logic [CELL_W-1:0] left_addr, right_addr;

  logic signed [ACC_W-1:0] acc;
  logic                    acc_last;
  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-ELEMENT_BITS:0] upper;
  logic                    sat;
  logic signed [ELEMENT_BITS-1:0] elem;

  logic     out_valid_q;
  mm4_out_t out_q;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_FRACTION_BITS);
  assign cfg_write = psel & penable & pwrite & cfg_hit;
  assign prdata    = cfg_hit ? {{(DATA_W - FRAC_W){1'b0}}, frac_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRACTION_RESET;
    end else if (cfg_write) begin
      frac_q <= pwdata[FRAC_W-1:0];
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_accept  = out_valid_q & ~out_stall_i;

  assign cur_row    = cell_q[DIM_W-1:0];
  assign cur_col    = cell_q[CELL_W-1:DIM_W];
  assign left_addr  = {k_q, cur_row};
  assign right_addr = {cur_col, k_q};

  // operand stores
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_mem[load_cnt_q]  <= in_data_i.left_element;
      right_mem[load_cnt_q] <= in_data_i.right_element;
    end
    rd_a_q <= left_mem[left_addr];
    rd_b_q <= right_mem[right_addr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_accept && load_cnt_q == CELL_W'(CELLS - 1)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == DIM_W'(DIM - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_accept) begin
          state_d = (cell_q == CELL_W'(CELLS - 1)) ? ST_LOAD : ST_ISSUE;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    rd_ctrl_d = '0;
    if (state_q == ST_ISSUE) begin
      rd_ctrl_d.valid = 1'b1;
      rd_ctrl_d.first = (k_q == '0);
      rd_ctrl_d.last  = (k_q == DIM_W'(DIM - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      cell_q      <= '0;
      k_q         <= '0;
      rd_ctrl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ctrl_q <= rd_ctrl_d;
      if (in_accept) begin
        load_cnt_q <= load_cnt_q + CELL_W'(1);
      end
      if (state_q == ST_ISSUE) begin
        k_q <= k_q + DIM_W'(1);
      end
      if (state_q == ST_DRAIN && acc_last) begin
        out_valid_q <= 1'b1;
      end
      if (out_accept) begin
        out_valid_q <= 1'b0;
        cell_q      <= cell_q + CELL_W'(1);
      end
    end
  end

  mm4_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rd_ctrl_q),
    .a_i        (rd_a_q),
    .b_i        (rd_b_q),
    .acc_o      (acc),
    .acc_last_o (acc_last)
  );

  // scale down and clip to the element range
  always_comb begin
    shifted = acc >>> frac_q;
    upper   = shifted[ACC_W-1:ELEMENT_BITS-1];
    sat     = ~((&upper) | ~(|upper));
    if (sat) begin
      elem = shifted[ACC_W-1] ? {1'b1, {(ELEMENT_BITS - 1){1'b0}}}
                              : {1'b0, {(ELEMENT_BITS - 1){1'b1}}};
    end else begin
      elem = shifted[ELEMENT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN && acc_last) begin
      out_q.product_element <= elem;
      out_q.element_index   <= INDEX_W'(cell_q);
      out_q.last_element    <= (cell_q == CELL_W'(CELLS - 1));
      out_q.saturated       <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/mm4_mac.sv =====
// shared multiply-accumulate unit: one registered product, one accumulate per cycle
module mm4_mac import mm4_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mm4_mac_ctrl_t                  ctrl_i,
  input  logic signed [ELEMENT_BITS-1:0] a_i,
  input  logic signed [ELEMENT_BITS-1:0] b_i,
  output logic signed [ACC_W-1:0]        acc_o,
  output logic                           acc_last_o
);

  logic signed [PROD_W-1:0] prod_q;
  mm4_mac_ctrl_t            prod_ctrl_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     acc_last_q;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (prod_ctrl_q.valid) begin
      if (prod_ctrl_q.first) begin
        acc_d = prod_ext;
      end else begin
        acc_d = acc_q + prod_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctrl_q <= '0;
      acc_last_q  <= 1'b0;
    end else begin
      prod_ctrl_q <= ctrl_i;
      acc_last_q  <= prod_ctrl_q.valid & prod_ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o      = acc_q;
  assign acc_last_o = acc_last_q;

endmodule

// ===== tb/sv/matrix4_multiply_test.sv =====
// self-checking testbench for the 4x4 fixed-point matrix multiplier
`timescale 1ns / 100ps

module matrix4_multiply_test;
  import mm4_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT     = 1000;
  localparam int unsigned SETTLE_CYCLES      = 12;
  localparam int unsigned RANDOM_PHASES      = 7;
  localparam int unsigned MATRICES_PER_PHASE = 3;
  localparam logic [FRAC_W-1:0] FRAC_MIN     = 5'd0;
  localparam logic [FRAC_W-1:0] FRAC_MAX     = 5'd31;
  localparam logic [ADDR_W-1:0] FRACTION_ADDR = {REG_FRACTION_BITS, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR   = 3'd4;
  localparam logic signed [31:0] EXTREMES [5] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1, 32'sd1
  };

  typedef enum int unsigned {FILL_FULL, FILL_SIZED, FILL_EXTREME, FILL_SCALED} fill_mode_e;

  class product_scoreboard;
    logic signed [31:0] left_cells [CELLS];
    logic signed [31:0] right_cells [CELLS];
    int unsigned        next_cell;
    logic [FRAC_W-1:0]  frac;
    mm4_out_t           awaited_products [$];
    int unsigned        errors;

    function new();
      next_cell = 0;
      frac      = FRACTION_RESET;
      errors    = 0;
    endfunction

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function int unsigned pending();
      return awaited_products.size();
    endfunction

    // exact sum of four products, floor shift, clip to 32 bits
    function mm4_out_t predict_element(int unsigned col, int unsigned row);
      logic signed [127:0] acc;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      mm4_out_t            r;
      int unsigned         flat_idx;
      acc    = '0;
      hi_lim = 128'sd2147483647;
      lo_lim = -128'sd2147483648;
      for (int k = 0; k < DIM; k++) begin
        a   = left_cells[k * DIM + row];
        b   = right_cells[col * DIM + k];
        acc = acc + a * b;
      end
      acc  = acc >>> frac;
      flat_idx = col * DIM + row;
      r.saturated = 1'b0;
      if (acc > hi_lim) begin
        acc         = hi_lim;
        r.saturated = 1'b1;
      end else if (acc < lo_lim) begin
        acc         = lo_lim;
        r.saturated = 1'b1;
      end
      r.product_element = acc[31:0];
      r.element_index   = flat_idx[INDEX_W-1:0];
      r.last_element    = (flat_idx == CELLS - 1);
      return r;
    endfunction

    function void note_request(mm4_in_t req);
      left_cells[next_cell]  = req.left_element;
      right_cells[next_cell] = req.right_element;
      if (next_cell == CELLS - 1) begin
        next_cell = 0;
        for (int col = 0; col < DIM; col++)
          for (int row = 0; row < DIM; row++)
            awaited_products.push_back(predict_element(col, row));
      end else begin
        next_cell++;
      end
    endfunction

    task check_product(input mm4_out_t got);
      mm4_out_t want;
      if (awaited_products.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = awaited_products.pop_front();
      if (got.product_element !== want.product_element)
        report($sformatf("element %0d: product %h, wanted %h", want.element_index,
                         got.product_element, want.product_element));
      if (got.element_index !== want.element_index)
        report($sformatf("index %0d, wanted %0d", got.element_index, want.element_index));
      if (got.last_element !== want.last_element)
        report($sformatf("element %0d: last flag %b, wanted %b", want.element_index,
                         got.last_element, want.last_element));
      if (got.saturated !== want.saturated)
        report($sformatf("element %0d: saturated %b, wanted %b", want.element_index,
                         got.saturated, want.saturated));
    endtask
  endclass

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  mm4_in_t           in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  mm4_out_t          out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              tx_quiet = 1'b0;
  logic              rx_quiet = 1'b0;
  int unsigned       rx_wait  = 0;
  int unsigned       idle_cycles = 0;

  product_scoreboard sb = new();

  always #10 clk_i = ~clk_i;

  matrix4_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // receiver: check each result, then stall for a drawn number of cycles
  always @(posedge clk_i) begin : rx_side
    int unsigned w;
    if (rst_ni) begin
      w = rx_wait;
      if (out_valid && !out_stall) begin
        sb.check_product(out_data);
        w = rx_quiet ? 0 : $urandom_range(0, 4);
      end
      out_stall <= (w != 0);
      rx_wait   <= (w != 0) ? w - 1 : 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [31:0] draw_element(fill_mode_e mode, logic [FRAC_W-1:0] f);
    int unsigned        bits;
    logic signed [31:0] raw;
    raw = $urandom;
    case (mode)
      FILL_FULL:   bits = 32;
      FILL_SIZED:  bits = $urandom_range(1, 32);
      FILL_SCALED: bits = (31 + f) / 2;
      default:     return EXTREMES[$urandom_range(0, 4)];
    endcase
    return raw >>> (32 - bits);
  endfunction

  task automatic send_request(input mm4_in_t req);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(req);
  endtask

  // hold off until every awaited result is in and the block has gone quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (write && addr == FRACTION_ADDR)
      sb.frac = wdata[FRAC_W-1:0];
  endtask

  task automatic check_fraction(input logic [FRAC_W-1:0] want);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, FRACTION_ADDR, '0, rd);
    if (rd !== DATA_W'(want))
      sb.report($sformatf("fraction_bits reads %h, wanted %h", rd, want));
  endtask

  task automatic set_fraction(input logic [FRAC_W-1:0] f);
    logic [DATA_W-1:0] rd;
    // junk in the unused upper bits
    apb_access(1'b1, FRACTION_ADDR, {27'($urandom), f}, rd);
    check_fraction(f);
  endtask

  initial begin
    mm4_in_t           req;
    logic [FRAC_W-1:0] f;
    logic [DATA_W-1:0] rd;
    fill_mode_e        mode;
    logic              quiet;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_fraction(FRACTION_RESET);
    set_fraction(FRAC_MAX);

    // extremes, with the format changed halfway through the matrix
    for (int i = 0; i < CELLS; i++) begin
      if (i == CELLS / 2) begin
        wait_drained();
        apb_access(1'b1, UNUSED_ADDR, $urandom, rd);
        check_fraction(FRAC_MAX);
        set_fraction(FRAC_MIN);
      end
      req.left_element  = EXTREMES[i % 5];
      req.right_element = EXTREMES[(3 * i + 1) % 5];
      send_request(req);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       f = FRAC_MIN;
        1:       f = FRAC_MAX;
        2:       f = FRACTION_RESET;
        default: f = $urandom_range(0, 31);
      endcase
      wait_drained();
      set_fraction(f);
      quiet     = ($urandom_range(0, 3) == 0);
      tx_quiet  = quiet;
      rx_quiet <= quiet;
      for (int m = 0; m < MATRICES_PER_PHASE; m++) begin
        mode = fill_mode_e'($urandom_range(0, 3));
        for (int i = 0; i < CELLS; i++) begin
          req.left_element  = draw_element(mode, f);
          req.right_element = draw_element(mode, f);
          send_request(req);
        end
        if ($urandom_range(0, 3) == 0)
          wait_drained();
      end
    end

    wait_drained();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
